FILE: design/assert_macros.svh
// Assertion helpers shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define U8D_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define U8D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/u8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

   localparam int BYTE_W      = 8;
   localparam int CODE_W      = 21;
   localparam int STATUS_W    = 2;
   localparam int PEND_W      = 2;
   localparam int RSP_TDATA_W = ((CODE_W + 7) / 8) * 8;
   localparam int CONT_BITS   = 6;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_ASCII,
      KIND_LEAD2,
      KIND_LEAD3,
      KIND_LEAD4,
      KIND_OTHER
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_TRUNCATED = 2'd2
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              last_byte;
      kind_type          kind;
   } entry_type;

endpackage

FILE: design/utf8_to_code_point_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// Turns a UTF-8 byte stream into code points, one byte per cycle unless the receiver stalls.
// ----------------------------------------------------------------------------
// Input channel req_*: one text byte per item in req_tdata, req_tlast on the
// final byte of a text. Result channel rsp_*: code point in rsp_tdata, status
// in rsp_tuser (ok, invalid lead, truncated), rsp_tlast on the result caused
// by the final byte. A byte that starts or only extends a multi-byte form
// gives no result unless it ends the text; every other byte gives exactly one.
// Throughput is one byte per cycle while the receiver keeps up: the front
// classifies each byte as it is taken, a two-entry queue carries it to the
// decode stage, which shifts six payload bits in and writes the result
// register in the same cycle. With an idle queue a byte goes from a queue
// entry to the result register. When the receiver stalls, the result
// register holds and the queue fills; req_tready drops once both queue
// entries are taken, and it returns in the cycle after rsp_tready does,
// after which the stream runs at full rate. Reset clears the queue, the
// result valid flag and the partial code, so the first byte after reset starts a new text. There is no clearing pass.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder import u8d_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,   // [7:0] text_byte
   input  logic                   req_tlast,   // last_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [20:0] code point, [23:21] zero
   output logic [STATUS_W-1:0]    rsp_tuser,   // [1:0] status
   output logic                   rsp_tlast    // end_of_text
);

   logic      q_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      q_valid;
   entry_type head;

   u8d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   u8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .head       (head)
   );

   u8d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: design/u8d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_front
// Input side: takes bytes off the stream and tags each with its byte class.
// ----------------------------------------------------------------------------
module u8d_front import u8d_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,   // [7:0] text_byte
   input  logic              req_tlast,   // last_byte
   input  logic              q_full,
   output logic              push,
   output entry_type         push_entry
);

   kind_type kind;

   always_comb begin
      if (req_tdata[7] == 1'b0) begin
         kind = KIND_ASCII;
      end else if (req_tdata[7:5] == 3'b110) begin
         kind = KIND_LEAD2;
      end else if (req_tdata[7:4] == 4'b1110) begin
         kind = KIND_LEAD3;
      end else if (req_tdata[7:3] == 5'b11110) begin
         kind = KIND_LEAD4;
      end else begin
         kind = KIND_OTHER;
      end
   end

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   always_comb begin
      push_entry.text_byte = req_tdata;
      push_entry.last_byte = req_tlast;
      push_entry.kind      = kind;
   end

   `include "assert_macros.svh"

   `U8D_ASSERT(a_ascii_class, clock, reset, !(push && (req_tdata[7] == 1'b0) && (kind != KIND_ASCII)), "byte below 0x80 not classed as ascii")

endmodule

FILE: design/u8d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_queue
// Short FIFO between the classify side and the decode side.
// ----------------------------------------------------------------------------
module u8d_queue import u8d_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      q_valid,
   output entry_type head
);

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + QPTR_W'(1);
   endfunction

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `include "assert_macros.svh"

   `U8D_ASSERT(a_no_overflow, clock, reset, !(push && full), "push into a full queue")
   `U8D_ASSERT(a_no_underflow, clock, reset, !(pop && !q_valid), "pop from an empty queue")

endmodule

FILE: design/u8d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_back
// Decode side: gathers payload bits and drives the registered result.
// ----------------------------------------------------------------------------
module u8d_back import u8d_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  entry_type              head,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [20:0] code point, [23:21] zero
   output logic [STATUS_W-1:0]    rsp_tuser,   // [1:0] status
   output logic                   rsp_tlast    // end_of_text
);

   logic [CODE_W-1:0] partial_ff, partial_in;
   logic [PEND_W-1:0] pending_ff, pending_in;
   logic              valid_ff, valid_in;
   logic [CODE_W-1:0] code_ff, code_in;
   status_type        status_ff, status_in;
   logic              eot_ff, eot_in;

   logic              emit;
   logic [CODE_W-1:0] shifted;
   logic [PEND_W-1:0] pending_dec;

   // Take the next item whenever the output slot is free or being drained.
   assign pop = q_valid && (!valid_ff || rsp_tready);

   assign shifted     = {partial_ff[CODE_W-CONT_BITS-1:0], head.text_byte[CONT_BITS-1:0]};
   assign pending_dec = pending_ff - PEND_W'(1);

   always_comb begin
      partial_in = partial_ff;
      pending_in = pending_ff;
      emit       = 1'b0;
      code_in    = '0;
      status_in  = ST_OK;
      eot_in     = head.last_byte;
      if (pending_ff != '0) begin
         partial_in = shifted;
         pending_in = pending_dec;
         if (pending_dec == '0) begin
            emit       = 1'b1;
            code_in    = shifted;
            partial_in = '0;
         end else if (head.last_byte) begin
            emit       = 1'b1;
            status_in  = ST_TRUNCATED;
            partial_in = '0;
            pending_in = '0;
         end
      end else begin
         case (head.kind)
            KIND_ASCII: begin
               emit    = 1'b1;
               code_in = CODE_W'(head.text_byte);
            end
            KIND_LEAD2: begin
               partial_in = CODE_W'(head.text_byte[4:0]);
               pending_in = PEND_W'(1);
            end
            KIND_LEAD3: begin
               partial_in = CODE_W'(head.text_byte[3:0]);
               pending_in = PEND_W'(2);
            end
            KIND_LEAD4: begin
               partial_in = CODE_W'(head.text_byte[2:0]);
               pending_in = PEND_W'(3);
            end
            default: begin
               emit      = 1'b1;
               status_in = ST_INVALID;
            end
         endcase
         // Lead byte that ends the text: drop the partial form.
         if (!emit && head.last_byte) begin
            emit       = 1'b1;
            status_in  = ST_TRUNCATED;
            partial_in = '0;
            pending_in = '0;
         end
      end
   end

   always_comb begin
      if (pop) begin
         valid_in = emit;
      end else begin
         valid_in = valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         pending_ff <= '0;
         valid_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (pop) begin
            partial_ff <= partial_in;
            pending_ff <= pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         code_ff   <= code_in;
         status_ff <= status_in;
         eot_ff    <= eot_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(code_ff);
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = eot_ff;

   `include "assert_macros.svh"

   `U8D_ASSERT(a_err_zero_code, clock, reset,
      !(valid_ff && (status_ff != ST_OK) && (code_ff != '0)),
      "error result with nonzero code point")
   `U8D_ASSERT(a_trunc_eot, clock, reset,
      !(valid_ff && (status_ff == ST_TRUNCATED) && !eot_ff),
      "truncated result without end of text")
   `U8D_ASSERT_NEXT(a_text_clears, clock, reset, pop && head.last_byte,
      (pending_ff == '0) && (partial_ff == '0), "state not cleared after last byte")

endmodule

FILE: sim/utf8_to_code_point_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_tb
// Streams UTF-8 texts into the decoder and checks every code point.
// A directed set covers the byte classes, the widest forms, invalid leads
// and cut-off sequences. Random texts of mostly well-formed sequences follow,
// mixed with noise bytes and forms that are cut short. Both channels idle in
// random bursts, and one long receiver hold-off lets the decoder back up.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_tb import u8d_pkg::*;;

   localparam int RANDOM_ITEMS   = 850;
   localparam int CALM_ITEMS     = 120;
   localparam int HOLD_AT        = 300;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct {
      logic [BYTE_W-1:0] text_byte;
      logic              last_byte;
   } text_item_type;

   typedef struct {
      logic [CODE_W-1:0] cp_value;
      status_type        status;
      logic              end_of_text;
   } code_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata  = '0;   // [7:0] text_byte
   logic                   req_tlast  = 1'b0; // last_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [20:0] code point, [23:21] zero
   logic [STATUS_W-1:0]    rsp_tuser;         // [1:0] status
   logic                   rsp_tlast;         // end_of_text

   text_item_type   text_bytes[$];
   code_result_type results_due[$];
   text_item_type   next_byte;

   logic [CODE_W-1:0] dec_partial = '0;
   logic [PEND_W-1:0] dec_pending = '0;

   bit req_fire    = 1'b0;
   int error_count = 0;
   int bytes_taken = 0;
   int idle_cycles = 0;
   int req_gap     = 0;
   int rsp_stall   = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;

   utf8_to_code_point_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("[%0t] mismatch: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
      error_count++;
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
      text_item_type it;
      it.text_byte = b;
      it.last_byte = last;
      text_bytes.insert(text_bytes.size(), it);
   endtask

   // Queue one n-byte form with random payload; cut drops trailing bytes.
   task automatic push_form(input int n, input bit fin, input bit cut);
      logic [BYTE_W-1:0] b;
      int count;
      count = cut ? $urandom_range(1, n - 1) : n;
      case (n)
         1: b = {1'b0, 7'($urandom)};
         2: b = {3'b110, 5'($urandom)};
         3: b = {4'b1110, 4'($urandom)};
         default: b = {5'b11110, 3'($urandom)};
      endcase
      push_byte(b, fin && count == 1);
      for (int k = 1; k < count; k++) begin
         // continuation bytes are masked, not checked: fuzz the tag now and then
         if ($urandom_range(0, 9) == 0) b = 8'($urandom);
         else b = {2'b10, 6'($urandom)};
         push_byte(b, fin && k == count - 1);
      end
   endtask

   // Predict the result of one accepted byte and queue it if there is one.
   task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic last);
      code_result_type r;
      bit has_result;
      has_result    = 1'b0;
      r.cp_value    = '0;
      r.status      = ST_OK;
      r.end_of_text = last;
      if (dec_pending != '0) begin
         dec_partial = {dec_partial[CODE_W-7:0], b[5:0]};
         dec_pending = dec_pending - 1'b1;
         if (dec_pending == '0) begin
            has_result  = 1'b1;
            r.cp_value  = dec_partial;
            dec_partial = '0;
         end else if (last) begin
            has_result    = 1'b1;
            r.status      = ST_TRUNCATED;
            r.end_of_text = 1'b1;
            dec_partial   = '0;
            dec_pending   = '0;
         end
      end else if (!b[7]) begin
         has_result = 1'b1;
         r.cp_value = CODE_W'(b);
      end else begin
         if (b[7:5] == 3'b110) begin
            dec_partial = CODE_W'(b[4:0]);
            dec_pending = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            dec_partial = CODE_W'(b[3:0]);
            dec_pending = 2'd2;
         end else if (b[7:3] == 5'b11110) begin
            dec_partial = CODE_W'(b[2:0]);
            dec_pending = 2'd3;
         end else begin
            has_result = 1'b1;
            r.status   = ST_INVALID;
         end
         // a multi-byte lead that is itself last truncates the text
         if (!has_result && last) begin
            has_result    = 1'b1;
            r.status      = ST_TRUNCATED;
            r.end_of_text = 1'b1;
            dec_partial   = '0;
            dec_pending   = '0;
         end
      end
      if (has_result) results_due.insert(results_due.size(), r);
   endtask

   // Sender: advance on acceptance, idle in bursts until the calm tail.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (text_bytes.size() > 0) begin
            next_byte = text_bytes.pop_front();
            req_tdata  <= next_byte.text_byte;
            req_tlast  <= next_byte.last_byte;
            req_tvalid <= 1'b1;
            if (text_bytes.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0)
               req_gap = $urandom_range(1, 17);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off to fill the decoder.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && bytes_taken >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else if (text_bytes.size() >= CALM_ITEMS && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(1, 17) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predict on accepted bytes, check accepted results, watch for hangs.
   always @(posedge clock) begin
      code_result_type want;
      req_fire = 1'b0;
      if (!reset) begin
         req_fire = req_tvalid && req_tready;
         if (req_fire) begin
            decode_byte(req_tdata, req_tlast);
            bytes_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               report_mismatch("unexpected result, tdata", 0, rsp_tdata);
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata !== RSP_TDATA_W'(want.cp_value))
                  report_mismatch("code point", want.cp_value, rsp_tdata);
               if (rsp_tuser !== want.status)
                  report_mismatch("status", want.status, rsp_tuser);
               if (rsp_tlast !== want.end_of_text)
                  report_mismatch("end_of_text", want.end_of_text, rsp_tlast);
            end
         end
         if (req_fire || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no item moved for %0d cycles", $realtime, idle_cycles);
            $display("** utf8_to_code_point_decoder: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      int len;
      int sel;
      // plain ASCII extremes
      push_byte(8'h00, 1'b0);
      push_byte(8'h7F, 1'b0);
      // two, three and four byte forms
      push_byte(8'hC2, 1'b0); push_byte(8'hA9, 1'b0);
      push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hAC, 1'b0);
      push_byte(8'hF0, 1'b0); push_byte(8'h9F, 1'b0); push_byte(8'h98, 1'b0);
      push_byte(8'h80, 1'b0);
      // widest payload, completing on the last byte of the text
      push_byte(8'hF7, 1'b0); push_byte(8'hBF, 1'b0); push_byte(8'hBF, 1'b0);
      push_byte(8'hBF, 1'b1);
      // overlong form passes through
      push_byte(8'hC0, 1'b0); push_byte(8'h80, 1'b0);
      // invalid leads: stray continuation, 11111xxx, and one that ends the text
      push_byte(8'h80, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'hF8, 1'b1);
      // truncated mid-form, then a lead byte that is itself last
      push_byte(8'hE2, 1'b0); push_byte(8'h82, 1'b1);
      push_byte(8'hC3, 1'b1);
      // a fresh text after the boundary
      push_byte(8'h41, 1'b1);

      while (text_bytes.size() < RANDOM_ITEMS) begin
         len = $urandom_range(1, 10);
         for (int k = 0; k < len; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 80) push_form($urandom_range(1, 4), k == len - 1, 1'b0);
            else if (sel < 90) push_byte(8'($urandom), k == len - 1);
            else push_form($urandom_range(2, 4), k == len - 1, 1'b1);
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (text_bytes.size() > 0 || req_tvalid) @(posedge clock);
      while (results_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (results_due.size() != 0)
         report_mismatch("results still due", 0, results_due.size());
      if (error_count == 0) begin
         $display("** utf8_to_code_point_decoder: PASSED **");
      end else begin
         $display("** utf8_to_code_point_decoder: FAILED **");
      end
      $finish;
   end

endmodule
